// ----- sv/slnu_pkg.sv -----
// ============================================================================
// slnu_pkg
// Shared widths, register codes, pipeline types and the divider step of the
// snake lattice neighbor unit.
// ============================================================================
package slnu_pkg;

    // clamp on each lattice side
    localparam int MAX_SIDE   = 64;

    // field widths
    localparam int SITE_W     = 13;
    localparam int SIDE_W     = 7;
    localparam int TOTAL_W    = 2 * SIDE_W;
    localparam int CFG_IDX_W  = 2;

    // largest side a 7-bit register can carry after the clamp
    localparam int SIDE_LIMIT = (1 << SIDE_W) - 1;
    localparam int EFF_MAX    = (MAX_SIDE > SIDE_LIMIT) ? SIDE_LIMIT : MAX_SIDE;

    // site divider: a few quotient bits per pipeline stage
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = (SIDE_W + DIV_BITS - 1) / DIV_BITS;
    localparam int QB         = DIV_STAGES * DIV_BITS;
    localparam int DVW        = SIDE_W + QB;

    // neighbor slots per site, in emission order
    localparam int NB         = 4;
    localparam int NB_IDX_W   = $clog2(NB);
    localparam int NB_Y_UP    = 0;
    localparam int NB_Y_DOWN  = 1;
    localparam int NB_X_UP    = 2;
    localparam int NB_X_DOWN  = 3;

    // queue between front and back
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // register reset values
    localparam logic [SIDE_W-1:0] SIDE_X_RST = SIDE_W'(4);
    localparam logic [SIDE_W-1:0] SIDE_Y_RST = SIDE_W'(4);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIDE_X     = 2'd0,
        CFG_SIDE_Y     = 2'd1,
        CFG_X_PERIODIC = 2'd2,
        CFG_Y_PERIODIC = 2'd3
    } cfg_index_t;

    // effective lattice configuration
    typedef struct packed {
        logic [SIDE_W-1:0] lx;
        logic [SIDE_W-1:0] ly;
        logic              xp;
        logic              yp;
    } lat_cfg_t;

    // one division in flight: partial remainder and quotient
    typedef struct packed {
        logic [SITE_W-1:0] rem;
        logic [QB-1:0]     q;
    } div_lane_t;

    // request state while the site numbers are divided
    typedef struct packed {
        logic              action;
        logic              range_error;
        logic [SITE_W-1:0] site_a;
        div_lane_t         lane_a;
        div_lane_t         lane_b;
    } div_state_t;

    // request state once row and column are known
    typedef struct packed {
        logic              action;
        logic              range_error;
        logic [SITE_W-1:0] site_a;
        logic [SITE_W-1:0] base_a;
        logic              odd_a;
        logic [SIDE_W-1:0] x_a;
        logic [SIDE_W-1:0] y_a;
        logic [SIDE_W-1:0] yb_a;
        logic [SIDE_W-1:0] x_b;
        logic [SIDE_W-1:0] y_b;
    } coord_t;

    // classified request waiting for the back end
    typedef struct packed {
        logic [NB-1:0][SITE_W-1:0] sites;
        logic [NB-1:0]             mask;
        logic                      adjacent;
        logic                      range_error;
    } entry_t;

    // restoring division, DIV_BITS quotient bits of the given stage
    function automatic div_lane_t div_step(div_lane_t lane, logic [SIDE_W-1:0] ly, int stage);
        div_lane_t        res;
        logic [DVW-1:0]   r;
        logic [DVW-1:0]   d;
        int               bitpos;
        res = lane;
        for (int j = 0; j < DIV_BITS; j++)
        begin
            bitpos = (DIV_STAGES - 1 - stage) * DIV_BITS + (DIV_BITS - 1 - j);
            r = DVW'(res.rem);
            d = DVW'(ly) << bitpos;
            if (r >= d)
            begin
                res.rem = SITE_W'(r - d);
                res.q   = res.q | (QB'(1) << bitpos);
            end
        end
        return res;
    endfunction

endpackage

// ----- sv/slnu_front.sv -----
// ============================================================================
// slnu_front
// Takes requests, checks range, divides site numbers into row and column over
// a short pipeline and classifies the request into one queue entry.
// ============================================================================
module slnu_front
    import slnu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lat_cfg_t          cfg,
    input  logic              in_push,
    output logic              in_full,
    input  logic              action,
    input  logic [SITE_W-1:0] site_a,
    input  logic [SITE_W-1:0] site_b,
    output logic              q_push,
    output entry_t            q_data,
    input  logic              q_full
);

    logic [DIV_STAGES:0] p_valid_reg;
    logic [DIV_STAGES:0] p_valid_next;
    div_state_t          p_reg  [DIV_STAGES+1];
    div_state_t          p_next [DIV_STAGES+1];
    logic                c_valid_reg;
    logic                c_valid_next;
    coord_t              c_reg;
    coord_t              c_next;

    logic                advance;
    logic                accept;
    logic [TOTAL_W-1:0]  total;
    logic                a_ok;
    logic                b_ok;

    // the whole pipeline holds while its last stage waits on a full queue
    assign advance = !(c_valid_reg && q_full);
    assign in_full = !advance;
    assign accept  = in_push && advance;
    assign q_push  = c_valid_reg && !q_full;

    // range check against the lattice size
    assign total = TOTAL_W'(cfg.lx) * TOTAL_W'(cfg.ly);
    assign a_ok  = (site_a != '0) && (TOTAL_W'(site_a) <= total);
    assign b_ok  = (site_b != '0) && (TOTAL_W'(site_b) <= total);

    // first stage load and divider stages
    always_comb
    begin
        p_next[0].action      = action;
        p_next[0].range_error = action ? !(a_ok && b_ok) : !a_ok;
        p_next[0].site_a      = site_a;
        p_next[0].lane_a.rem  = site_a - SITE_W'(1);
        p_next[0].lane_a.q    = '0;
        p_next[0].lane_b.rem  = site_b - SITE_W'(1);
        p_next[0].lane_b.q    = '0;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            p_next[k+1]        = p_reg[k];
            p_next[k+1].lane_a = div_step(p_reg[k].lane_a, cfg.ly, k);
            p_next[k+1].lane_b = div_step(p_reg[k].lane_b, cfg.ly, k);
        end
    end

    // row and column from quotient and remainder
    always_comb
    begin
        div_state_t        d;
        logic [SIDE_W-1:0] r_a;
        logic [SIDE_W-1:0] r_b;
        logic              odd_b;
        d     = p_reg[DIV_STAGES];
        r_a   = SIDE_W'(d.lane_a.rem);
        r_b   = SIDE_W'(d.lane_b.rem);
        odd_b = ~d.lane_b.q[0];
        c_next.action      = d.action;
        c_next.range_error = d.range_error;
        c_next.site_a      = d.site_a;
        c_next.base_a      = d.site_a - SITE_W'(1) - d.lane_a.rem;
        c_next.odd_a       = ~d.lane_a.q[0];
        c_next.x_a         = SIDE_W'(d.lane_a.q) + SIDE_W'(1);
        c_next.y_a         = c_next.odd_a ? r_a + SIDE_W'(1) : cfg.ly - r_a;
        c_next.yb_a        = c_next.odd_a ? cfg.ly - r_a : r_a + SIDE_W'(1);
        c_next.x_b         = SIDE_W'(d.lane_b.q) + SIDE_W'(1);
        c_next.y_b         = odd_b ? r_b + SIDE_W'(1) : cfg.ly - r_b;
    end

    // valid bits
    always_comb
    begin
        p_valid_next = p_valid_reg;
        c_valid_next = c_valid_reg;
        if (advance)
        begin
            p_valid_next = {p_valid_reg[DIV_STAGES-1:0], accept};
            c_valid_next = p_valid_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= '0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k <= DIV_STAGES; k++)
            begin
                p_reg[k] <= p_next[k];
            end
            c_reg <= c_next;
        end
    end

    // neighbor candidates and adjacency test
    always_comb
    begin
        logic [SITE_W-1:0] ly_s;
        logic [SITE_W-1:0] opp_off;
        logic [SITE_W-1:0] last_off;
        logic              wrap_x;
        logic              wrap_y;
        logic [SIDE_W-1:0] dx;
        logic [SIDE_W-1:0] dy;
        logic              adj;
        ly_s     = SITE_W'(cfg.ly);
        opp_off  = SITE_W'(c_reg.odd_a ? c_reg.yb_a : c_reg.y_a);
        last_off = SITE_W'(cfg.lx[0] ? c_reg.y_a : c_reg.yb_a);
        wrap_x   = cfg.xp && (cfg.lx >= SIDE_W'(3));
        wrap_y   = cfg.yp && (cfg.ly >= SIDE_W'(3));

        q_data.sites = '0;
        q_data.mask  = '0;

        // y + 1
        if (c_reg.y_a < cfg.ly)
        begin
            q_data.sites[NB_Y_UP] = c_reg.odd_a ? c_reg.site_a + SITE_W'(1)
                                                : c_reg.site_a - SITE_W'(1);
            q_data.mask[NB_Y_UP]  = 1'b1;
        end
        else if (wrap_y)
        begin
            q_data.sites[NB_Y_UP] = c_reg.odd_a ? c_reg.base_a + SITE_W'(1)
                                                : c_reg.base_a + ly_s;
            q_data.mask[NB_Y_UP]  = 1'b1;
        end

        // y - 1
        if (c_reg.y_a > SIDE_W'(1))
        begin
            q_data.sites[NB_Y_DOWN] = c_reg.odd_a ? c_reg.site_a - SITE_W'(1)
                                                  : c_reg.site_a + SITE_W'(1);
            q_data.mask[NB_Y_DOWN]  = 1'b1;
        end
        else if (wrap_y)
        begin
            q_data.sites[NB_Y_DOWN] = c_reg.odd_a ? c_reg.base_a + ly_s
                                                  : c_reg.base_a + SITE_W'(1);
            q_data.mask[NB_Y_DOWN]  = 1'b1;
        end

        // x + 1
        if (c_reg.x_a < cfg.lx)
        begin
            q_data.sites[NB_X_UP] = c_reg.base_a + ly_s + opp_off;
            q_data.mask[NB_X_UP]  = 1'b1;
        end
        else if (wrap_x)
        begin
            q_data.sites[NB_X_UP] = SITE_W'(c_reg.y_a);
            q_data.mask[NB_X_UP]  = 1'b1;
        end

        // x - 1
        if (c_reg.x_a > SIDE_W'(1))
        begin
            q_data.sites[NB_X_DOWN] = c_reg.base_a - ly_s + opp_off;
            q_data.mask[NB_X_DOWN]  = 1'b1;
        end
        else if (wrap_x)
        begin
            q_data.sites[NB_X_DOWN] = SITE_W'(total) - ly_s + last_off;
            q_data.mask[NB_X_DOWN]  = 1'b1;
        end

        // adjacency, counting periodic wrap
        dx  = (c_reg.x_a >= c_reg.x_b) ? c_reg.x_a - c_reg.x_b : c_reg.x_b - c_reg.x_a;
        dy  = (c_reg.y_a >= c_reg.y_b) ? c_reg.y_a - c_reg.y_b : c_reg.y_b - c_reg.y_a;
        adj = ((dx == '0) || (dy == '0)) &&
              ((dx == SIDE_W'(1)) || (dy == SIDE_W'(1)) ||
               (cfg.xp && (dx != '0) && (dx == cfg.lx - SIDE_W'(1))) ||
               (cfg.yp && (dy != '0) && (dy == cfg.ly - SIDE_W'(1))));

        // out of range and adjacency requests give a single plain result
        q_data.adjacent    = 1'b0;
        q_data.range_error = 1'b0;
        if (c_reg.range_error)
        begin
            q_data.mask        = '0;
            q_data.range_error = 1'b1;
        end
        else if (c_reg.action)
        begin
            q_data.mask     = '0;
            q_data.adjacent = adj;
        end
    end

endmodule

// ----- sv/slnu_queue.sv -----
// ============================================================================
// slnu_queue
// Short first-in first-out queue of classified requests between the front
// and the back end.
// ============================================================================
module slnu_queue
    import slnu_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t wr_data,
    output logic   q_full,
    input  logic   q_pop,
    output entry_t rd_data,
    output logic   q_empty
);

    entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign q_full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_empty = (count_reg == '0);
    assign do_push = push && !q_full;
    assign do_pop  = q_pop && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointers wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- sv/slnu_back.sv -----
// ============================================================================
// slnu_back
// Walks the head queue entry and emits one result per cycle, while the
// output register is free or being taken, lowest pending neighbor slot first.
// ============================================================================
module slnu_back
    import slnu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  entry_t            head,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output logic [SITE_W-1:0] neighbor_site,
    output logic              found,
    output logic              adjacent,
    output logic              range_error,
    output logic              last
);

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [NB-1:0]       done_reg;
    logic [NB-1:0]       done_next;
    logic [SITE_W-1:0]   site_reg;
    logic [SITE_W-1:0]   site_next;
    logic                found_reg;
    logic                found_next;
    logic                adj_reg;
    logic                adj_next;
    logic                rerr_reg;
    logic                rerr_next;
    logic                last_reg;
    logic                last_next;

    logic                load;
    logic [NB-1:0]       pending;
    logic [NB_IDX_W-1:0] idx;
    logic [NB-1:0]       sel;
    logic                final_one;

    // output register refills from a non-empty queue when free or being taken
    assign load    = !q_empty && (!out_valid_reg || pop);
    assign pending = head.mask & ~done_reg;

    // lowest pending slot
    always_comb
    begin
        idx = '0;
        for (int i = NB - 1; i >= 0; i--)
        begin
            if (pending[i])
            begin
                idx = NB_IDX_W'(i);
            end
        end
    end

    assign sel       = NB'(1) << idx;
    assign final_one = ((pending & ~sel) == '0);
    assign q_pop     = load && final_one;

    // next result and walk state
    always_comb
    begin
        site_next  = site_reg;
        found_next = found_reg;
        adj_next   = adj_reg;
        rerr_next  = rerr_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        if (load)
        begin
            if (head.mask != '0)
            begin
                site_next  = head.sites[idx];
                found_next = 1'b1;
                adj_next   = 1'b0;
                rerr_next  = 1'b0;
            end
            else
            begin
                site_next  = '0;
                found_next = 1'b0;
                adj_next   = head.adjacent;
                rerr_next  = head.range_error;
            end
            last_next = final_one;
            done_next = final_one ? '0 : (done_reg | sel);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            done_reg      <= done_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        site_reg  <= site_next;
        found_reg <= found_next;
        adj_reg   <= adj_next;
        rerr_reg  <= rerr_next;
        last_reg  <= last_next;
    end

    assign empty         = !out_valid_reg;
    assign neighbor_site = site_reg;
    assign found         = found_reg;
    assign adjacent      = adj_reg;
    assign range_error   = rerr_reg;
    assign last          = last_reg;

endmodule

// ----- sv/snake_lattice_neighbor_unit.sv -----
// ============================================================================
// snake_lattice_neighbor_unit
// Neighbor listing and adjacency test on a snake-numbered square lattice.
// ============================================================================
// Requests enter through push/full: one is taken at a clock edge with push
// high and full low. Action 0 lists the neighbors of site_a (y+1, y-1, x+1,
// x-1); action 1 tests site_a and site_b for adjacency.
// Results leave through empty/pop: the oldest result sits on the result ports
// while empty is low and is taken at an edge with pop high. Each request
// gives one to four results, the final one marked by last.
// Path: the first result of a request passes the range check stage, four
// divider stages, the coordinate stage, the queue and the output register.
// Throughput: one result per cycle from the output register while pop is
// held high; the divider pipeline takes a new request every cycle while
// full is low.
// A stalled receiver fills the output register, then the four-entry queue,
// then the front pipeline, and full rises; nothing is dropped.
// Configuration is written through cfg_write/cfg_index/cfg_data while no
// request is in flight. Reset empties all stages and sets a 4 by 4 lattice
// with open boundaries.
// ============================================================================
module snake_lattice_neighbor_unit
    import slnu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIDE_W-1:0]    cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic                 action,
    input  logic [SITE_W-1:0]    site_a,
    input  logic [SITE_W-1:0]    site_b,
    output logic                 empty,
    input  logic                 pop,
    output logic [SITE_W-1:0]    neighbor_site,
    output logic                 found,
    output logic                 adjacent,
    output logic                 range_error,
    output logic                 last
);

    logic [SIDE_W-1:0] side_x_reg;
    logic [SIDE_W-1:0] side_y_reg;
    logic              x_periodic_reg;
    logic              y_periodic_reg;
    lat_cfg_t          cfg;

    logic              q_push;
    entry_t            q_wr_data;
    logic              q_full;
    logic              q_pop;
    entry_t            q_head;
    logic              q_empty;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_x_reg     <= SIDE_X_RST;
            side_y_reg     <= SIDE_Y_RST;
            x_periodic_reg <= 1'b0;
            y_periodic_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SIDE_X:     side_x_reg     <= cfg_data;
                CFG_SIDE_Y:     side_y_reg     <= cfg_data;
                CFG_X_PERIODIC: x_periodic_reg <= cfg_data[0];
                CFG_Y_PERIODIC: y_periodic_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // sides clamped to the supported maximum
    always_comb
    begin
        cfg.lx = (side_x_reg > SIDE_W'(EFF_MAX)) ? SIDE_W'(EFF_MAX) : side_x_reg;
        cfg.ly = (side_y_reg > SIDE_W'(EFF_MAX)) ? SIDE_W'(EFF_MAX) : side_y_reg;
        cfg.xp = x_periodic_reg;
        cfg.yp = y_periodic_reg;
    end

    slnu_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .in_push (push),
        .in_full (full),
        .action  (action),
        .site_a  (site_a),
        .site_b  (site_b),
        .q_push  (q_push),
        .q_data  (q_wr_data),
        .q_full  (q_full)
    );

    slnu_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .rd_data (q_head),
        .q_empty (q_empty)
    );

    slnu_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .neighbor_site (neighbor_site),
        .found         (found),
        .adjacent      (adjacent),
        .range_error   (range_error),
        .last          (last)
    );

endmodule
